// ----- hw/rtl/owsrch_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owsrch_pkg: shared types and codes for the ROM search engine
// Operation and status codes plus the control word driven into the cell row.
// ---------------------------------------------------------------------------
package owsrch_pkg;

	// operation codes carried in the input tuser
	localparam logic [1:0] OP_PAIR  = 2'd0;
	localparam logic [1:0] OP_FIRST = 2'd1;
	localparam logic [1:0] OP_NEXT  = 2'd2;

	// status codes carried in the output tuser
	localparam logic [2:0] ST_CONTINUE = 3'd0;
	localparam logic [2:0] ST_FOUND    = 3'd1;
	localparam logic [2:0] ST_NO_MORE  = 3'd2;
	localparam logic [2:0] ST_RESTART  = 3'd3;
	localparam logic [2:0] ST_VANISHED = 3'd4;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 72;
	localparam int IN_USER_W  = 2;
	localparam int OUT_USER_W = 3;
	localparam int ADDR_W     = 64;

	// control word broadcast to every cell of the row
	typedef struct packed {
		logic load;    // take the previous ID bit from the start-next transfer
		logic rotate;  // previous ID ring moves one place towards cell 0
		logic shift;   // new ID row moves one place towards cell 0
	} cell_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/owsrch_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owsrch_cell: one ID bit slot of the search row
// Holds one bit of the previous ID ring and one bit of the ID being built.
// ---------------------------------------------------------------------------
module owsrch_cell (
	input  wire                   clk,
	input  owsrch_pkg::cell_ctl_t ctl,
	input  wire                   load_bit,
	input  wire                   prev_in,
	input  wire                   new_in,
	output logic                  prev_bit,
	output logic                  new_bit
);
	import owsrch_pkg::*;

	logic prev_q;
	logic new_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			prev_q <= load_bit;
		end else if (ctl.rotate) begin
			prev_q <= prev_in;
		end
		if (ctl.shift) begin
			new_q <= new_in;
		end
	end

	assign prev_bit = prev_q;
	assign new_bit  = new_q;

endmodule
`default_nettype wire

// ----- hw/rtl/onewire_rom_search_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// onewire_rom_search_engine: Search ROM (0xF0) direction decision engine
// Takes one sampled bit/complement pair per transfer, returns the bit to write.
// ---------------------------------------------------------------------------
// One input transfer gives exactly one output transfer, from a registered output; a new
// transfer is taken every cycle while the output register is empty or being
// drained, so the sustained rate is one item per clock. Op 1 starts a first
// search (lowest branch everywhere); op 2 loads the previous ID and starts a
// replay pass over all ROM_BITS bits. That pass ends with status no-more or
// restart; after a restart the host re-issues 0xF0 and feeds the pairs again:
// the engine replays the previous bits up to the last unexplored 0/0 branch,
// writes 1 there and finishes on the lowest branch, ending with status found
// and the ID in found_address. A 1/1 pair or a pair that contradicts the
// previous ID ends the search with status vanished. The ID lives in a row of
// ROM_BITS cells: the previous ID rotates one place per pair so that the bit
// in hand always sits in cell 0, and each written bit enters the new-ID row
// at the top and walks down, so no wide bit select is needed. Op 3 and pairs
// while idle answer write_bit 0, status continue, and change nothing.
// ---------------------------------------------------------------------------
module onewire_rom_search_engine #(
	parameter int ROM_BITS = 64
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// input stream
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [0] id_bit, [1] cmp_bit, [65:2] prev_address, [71:66] zero
	input  wire  [owsrch_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// [1:0] op
	input  wire  [owsrch_pkg::IN_USER_W-1:0]      s_axis_tuser,
	// result stream
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	// [0] write_bit, [64:1] found_address, [71:65] zero
	output logic [owsrch_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// [2:0] status
	output logic [owsrch_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
	import owsrch_pkg::*;

	localparam int PW = $clog2(ROM_BITS);
	localparam int BW = PW + 1;
	localparam logic [PW-1:0] LAST_POS  = PW'(ROM_BITS - 1);
	localparam logic [BW-1:0] NO_BRANCH = BW'(ROM_BITS);

	// search phase codes
	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_COMPLETE = 3'd1;
	localparam logic [2:0] PH_SCAN     = 3'd2;
	localparam logic [2:0] PH_TRACK    = 3'd3;
	localparam logic [2:0] PH_BRANCH   = 3'd4;

	logic [2:0]    phase_q,  phase_d;
	logic [PW-1:0] bitpos_q, bitpos_d;
	logic [BW-1:0] branch_q, branch_d;

	// output register
	logic                  out_valid_q;
	logic                  out_wr_q;
	logic [2:0]            out_st_q;
	logic [ADDR_W-1:0]     out_found_q;

	// cell row
	cell_ctl_t     ctl;
	logic [ROM_BITS-1:0] prev_row;
	logic [ROM_BITS-1:0] new_row;
	logic [ROM_BITS-1:0] prev_nb;   // neighbour inputs
	logic [ROM_BITS-1:0] new_nb;

	// transfer fields
	logic          take;
	logic [1:0]    op;
	logic          b_in;
	logic          c_in;
	logic [ROM_BITS-1:0] load_id;

	logic          pb;        // previous ID bit at the current position
	logic          vanish;
	logic          wr;
	logic [2:0]    st;
	logic [ROM_BITS-1:0] found;
	logic          at_last;
	logic [BW-1:0] pos_inc;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign op            = s_axis_tuser;
	assign b_in          = s_axis_tdata[0];
	assign c_in          = s_axis_tdata[1];
	assign load_id       = s_axis_tdata[ROM_BITS+1:2];

	assign pb      = prev_row[0];
	assign at_last = (bitpos_q == LAST_POS);
	assign pos_inc = {1'b0, bitpos_q} + BW'(1);

	// ring and row wiring: each cell hands its bit one place down
	assign prev_nb = {prev_row[0], prev_row[ROM_BITS-1:1]};
	assign new_nb  = {wr, new_row[ROM_BITS-1:1]};

	always_comb begin
		phase_d  = phase_q;
		bitpos_d = bitpos_q;
		branch_d = branch_q;
		wr       = 1'b0;
		st       = ST_CONTINUE;
		found    = '0;
		ctl      = '0;
		vanish   = 1'b0;
		if (take) begin
			case (op)
				OP_FIRST: begin
					phase_d  = PH_COMPLETE;
					bitpos_d = '0;
					branch_d = NO_BRANCH;
				end
				OP_NEXT: begin
					phase_d  = PH_SCAN;
					bitpos_d = '0;
					branch_d = NO_BRANCH;
					ctl.load = 1'b1;
				end
				OP_PAIR: begin
					if (phase_q != PH_IDLE) begin
						vanish = b_in && c_in;
						if ((phase_q inside {PH_SCAN, PH_TRACK})
								&& (b_in != c_in) && (pb != b_in)) begin
							vanish = 1'b1;
						end
						if (phase_q == PH_BRANCH && (b_in != c_in)) begin
							vanish = 1'b1;
						end
						if (vanish) begin
							st      = ST_VANISHED;
							phase_d = PH_IDLE;
						end else begin
							ctl.shift = 1'b1;
							case (phase_q)
								PH_SCAN: begin
									ctl.rotate = 1'b1;
									wr = pb;
									if (!b_in && !c_in && !pb) begin
										branch_d = {1'b0, bitpos_q};
									end
									if (at_last) begin
										bitpos_d = '0;
										if (branch_d == NO_BRANCH) begin
											st      = ST_NO_MORE;
											phase_d = PH_IDLE;
										end else begin
											st      = ST_RESTART;
											phase_d = (branch_d == '0) ? PH_BRANCH
												: PH_TRACK;
										end
									end else begin
										bitpos_d = bitpos_q + PW'(1);
									end
								end
								PH_TRACK: begin
									ctl.rotate = 1'b1;
									wr = pb;
									bitpos_d = pos_inc[PW-1:0];
									if (pos_inc >= branch_q) begin
										phase_d = PH_BRANCH;
									end
								end
								PH_BRANCH: begin
									ctl.rotate = 1'b1;
									wr = 1'b1;
									if (at_last) begin
										st      = ST_FOUND;
										found   = {wr, new_row[ROM_BITS-1:1]};
										phase_d = PH_IDLE;
									end else begin
										phase_d  = PH_COMPLETE;
										bitpos_d = bitpos_q + PW'(1);
									end
								end
								default: begin
									// complete: follow the lowest branch
									wr = b_in;
									if (at_last) begin
										st       = ST_FOUND;
										found    = {wr, new_row[ROM_BITS-1:1]};
										phase_d  = PH_IDLE;
										bitpos_d = '0;
									end else begin
										bitpos_d = bitpos_q + PW'(1);
									end
								end
							endcase
						end
					end
				end
				default: begin
					// undefined op: no change
				end
			endcase
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < ROM_BITS; gi++) begin : g_cell
			owsrch_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.load_bit (load_id[gi]),
				.prev_in  (prev_nb[gi]),
				.new_in   (new_nb[gi]),
				.prev_bit (prev_row[gi]),
				.new_bit  (new_row[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bitpos_q    <= '0;
			branch_q    <= NO_BRANCH;
			out_valid_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			bitpos_q <= bitpos_d;
			branch_q <= branch_d;
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			out_wr_q    <= wr;
			out_st_q    <= st;
			out_found_q <= ADDR_W'(found);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_found_q, out_wr_q};
	assign m_axis_tuser  = out_st_q;

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for onewire_rom_search_engine
// Drives Search ROM pair streams from a virtual bus of devices, predicts the
// direction bit, status and found ID of every transfer and checks them.
// ---------------------------------------------------------------------------
module testbench;
	import owsrch_pkg::*;

	localparam logic [1:0]  OP_RESERVED = 2'd3;
	localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int          ITEM_TARGET = 1200;
	localparam int          MAX_DEVS    = 8;

	typedef enum logic [2:0] {
		PH_IDLE, PH_COMPLETE, PH_SCAN, PH_TRACK, PH_BRANCH
	} search_phase_t;

	typedef struct packed {
		logic        write_bit;
		logic [2:0]  status;
		logic [63:0] found_address;
	} search_answer_t;

	// Search state shadow plus the queue of answers still to come out.
	class direction_checker_t;
		search_phase_t  phase;
		logic [5:0]     bit_pos;
		logic [6:0]     branch_off;
		logic [63:0]    prev_id;
		logic [63:0]    new_id;
		search_answer_t answers_due[$];
		int             failures;

		function new();
			phase      = PH_IDLE;
			bit_pos    = '0;
			branch_off = 7'd64;
			prev_id    = '0;
			new_id     = '0;
			failures   = 0;
		endfunction

		function bit searching();
			return phase != PH_IDLE;
		endfunction

		function bit at_branch();
			return phase == PH_BRANCH;
		endfunction

		function search_answer_t take_item(logic [1:0] op, logic b, logic c,
				logic [63:0] prev);
			search_answer_t a;
			logic [5:0]     i;
			logic [5:0]     off;
			logic [6:0]     nxt;
			logic [63:0]    low;
			logic           pb;
			bit             vanish;
			a   = '0;
			i   = bit_pos;
			pb  = prev_id[i];
			off = branch_off[5:0];
			case (op)
				OP_FIRST: begin
					phase      = PH_COMPLETE;
					bit_pos    = '0;
					branch_off = 7'd64;
					new_id     = '0;
				end
				OP_NEXT: begin
					prev_id    = prev;
					phase      = PH_SCAN;
					bit_pos    = '0;
					branch_off = 7'd64;
					new_id     = '0;
				end
				OP_PAIR: begin
					if (phase != PH_IDLE) begin
						vanish = b && c;
						if ((phase inside {PH_SCAN, PH_TRACK}) && b != c && pb != b)
							vanish = 1'b1;
						if (phase == PH_BRANCH && b != c)
							vanish = 1'b1;
						if (vanish) begin
							a.status = ST_VANISHED;
							phase    = PH_IDLE;
						end else begin
							case (phase)
								PH_SCAN: begin
									if (!b && !c && !pb)
										branch_off = {1'b0, i};
									a.write_bit = pb;
									if (i == 6'd63) begin
										bit_pos = '0;
										if (branch_off[6]) begin
											a.status = ST_NO_MORE;
											phase    = PH_IDLE;
										end else begin
											a.status = ST_RESTART;
											phase = (branch_off == 7'd0) ? PH_BRANCH : PH_TRACK;
										end
									end else begin
										bit_pos = i + 6'd1;
									end
								end
								PH_TRACK: begin
									a.write_bit = pb;
									nxt         = {1'b0, i} + 7'd1;
									bit_pos     = nxt[5:0];
									if (nxt >= branch_off)
										phase = PH_BRANCH;
								end
								PH_BRANCH: begin
									low         = (64'd1 << off) - 64'd1;
									a.write_bit = 1'b1;
									new_id      = (prev_id & low) | (64'd1 << off);
									if (off == 6'd63) begin
										a.status        = ST_FOUND;
										a.found_address = new_id;
										phase           = PH_IDLE;
									end else begin
										phase   = PH_COMPLETE;
										bit_pos = off + 6'd1;
									end
								end
								default: begin
									a.write_bit = b;
									new_id[i]   = b;
									if (i == 6'd63) begin
										a.status        = ST_FOUND;
										a.found_address = new_id;
										phase           = PH_IDLE;
										bit_pos         = '0;
									end else begin
										bit_pos = i + 6'd1;
									end
								end
							endcase
						end
					end
				end
				default: ; // reserved op: no effect
			endcase
			answers_due.push_back(a);
			return a;
		endfunction

		function void check_answer(search_answer_t got);
			search_answer_t want;
			if (answers_due.size() == 0) begin
				$error("result with nothing outstanding: write_bit %0d status %0d",
					got.write_bit, got.status);
				failures++;
				return;
			end
			want = answers_due.pop_front();
			if (got.write_bit !== want.write_bit) begin
				$error("write_bit: expected %0d, actual %0d", want.write_bit, got.write_bit);
				failures++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				failures++;
			end
			if (got.found_address !== want.found_address) begin
				$error("found_address: expected %h, actual %h",
					want.found_address, got.found_address);
				failures++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;  // [0] id_bit, [1] cmp_bit, [65:2] prev_address
	logic [IN_USER_W-1:0]   s_axis_tuser  = '0;  // [1:0] op
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;        // [0] write_bit, [64:1] found_address
	logic [OUT_USER_W-1:0]  m_axis_tuser;        // [2:0] status

	direction_checker_t chk;
	bit               steady = 1'b0;   // no idling on either side while set
	int               items_sent = 0;
	logic [63:0]      devs [MAX_DEVS];
	int               n_devs = 1;
	logic [7:0]       present = '0;

	onewire_rom_search_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit stall_now();
		return !steady && ($urandom_range(99) < 35);
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic send_item(input logic [1:0] op, input logic b, input logic c,
			input logic [63:0] prev, output search_answer_t ans);
		steady = (items_sent >= 500) && (items_sent < 750);
		while (stall_now()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {6'd0, prev, c, b};
		do @(posedge clk); while (!s_axis_tready);
		ans = chk.take_item(op, b, c, prev);
		items_sent++;
	endtask

	// Devices share prefixes so that discrepancies appear; bit 0 and bit 63
	// are favoured as the first differing bit.
	task automatic make_devices();
		int          src;
		int          p;
		int          roll;
		logic [63:0] hi;
		n_devs  = $urandom_range(5, 1);
		devs[0] = rand_word();
		for (int k = 1; k < n_devs; k++) begin
			src  = $urandom_range(k - 1);
			roll = $urandom_range(99);
			p    = (roll < 12) ? 0 : (roll < 24) ? 63 : $urandom_range(63);
			hi   = ~((64'd2 << p) - 64'd1);
			devs[k] = devs[src] ^ (64'd1 << p);
			devs[k] = (devs[k] & ~hi) | (rand_word() & hi);
		end
		present = (8'd1 << n_devs) - 8'd1;
	endtask

	// One pass of up to 64 pairs as the wired-AND bus would give them.
	task automatic run_pass(output search_answer_t last);
		logic [7:0]     live;
		int             fault_at;
		int             fault_kind;
		bit             branch_fault;
		logic           b;
		logic           c;
		search_answer_t ans;
		live         = present;
		fault_at     = ($urandom_range(99) < 8) ? $urandom_range(63) : -1;
		fault_kind   = $urandom_range(4);
		branch_fault = $urandom_range(99) < 10;
		last         = '0;
		for (int p = 0; p < 64; p++) begin
			b = 1'b1;
			c = 1'b1;
			for (int k = 0; k < n_devs; k++)
				if (live[k]) begin
					b &= devs[k][p];
					c &= ~devs[k][p];
				end
			if (branch_fault && chk.at_branch()) begin
				b = 1'($urandom_range(1));
				c = ~b;
			end
			if (p == fault_at) begin
				case (fault_kind)
					0: begin
						b = 1'b1;
						c = 1'b1;
					end
					1: b = ~b;
					2: c = ~c;
					3: send_item(OP_RESERVED, 1'($urandom_range(1)), 1'($urandom_range(1)),
						rand_word(), ans);
					default: begin
						// host gives up and starts over mid-pass
						send_item($urandom_range(1) ? OP_FIRST : OP_NEXT, b, c,
							rand_word(), last);
						break;
					end
				endcase
			end
			send_item(OP_PAIR, b, c, rand_word(), ans);
			last = ans;
			for (int k = 0; k < n_devs; k++)
				if (devs[k][p] != ans.write_bit)
					live[k] = 1'b0;
			if (ans.status != ST_CONTINUE)
				break;
		end
	endtask

	task automatic enumerate_bus();
		search_answer_t r;
		logic [63:0]    last_id;
		make_devices();
		send_item(OP_FIRST, 1'($urandom_range(1)), 1'($urandom_range(1)), rand_word(), r);
		run_pass(r);
		if (r.status != ST_FOUND)
			return;
		last_id = r.found_address;
		for (int round = 0; round <= n_devs; round++) begin
			// occasionally a device drops off the bus between searches
			if (n_devs > 1 && $urandom_range(99) < 5)
				present[$urandom_range(n_devs - 1)] = 1'b0;
			send_item(OP_NEXT, 1'($urandom_range(1)), 1'($urandom_range(1)), last_id, r);
			run_pass(r);
			if (r.status != ST_RESTART)
				break;
			if ($urandom_range(9) == 0)
				send_item(OP_RESERVED, 1'b0, 1'b0, rand_word(), r);
			run_pass(r);
			if (r.status != ST_FOUND)
				break;
			last_id = r.found_address;
		end
	endtask

	task automatic noise_burst();
		search_answer_t r;
		logic [63:0]    prev;
		int             roll;
		repeat ($urandom_range(12, 1)) begin
			roll = $urandom_range(99);
			prev = (roll < 10) ? 64'd0 : (roll < 20) ? ALL_ONES : rand_word();
			send_item(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
				prev, r);
		end
	endtask

	// result side: check every transfer, stall at random
	initial begin
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				chk.check_answer({m_axis_tdata[0], m_axis_tuser[2:0], m_axis_tdata[64:1]});
			m_axis_tready <= !stall_now();
		end
	end

	initial begin
		search_answer_t a;
		int             guard;
		chk = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reserved op and pairs while idle
		send_item(OP_RESERVED, 1'b0, 1'b0, 64'd0, a);
		send_item(OP_PAIR, 1'b0, 1'b0, 64'd0, a);
		send_item(OP_PAIR, 1'b1, 1'b1, ALL_ONES, a);
		// first search, all devices gone
		send_item(OP_FIRST, 1'b0, 1'b0, ALL_ONES, a);
		send_item(OP_PAIR, 1'b1, 1'b1, 64'd0, a);
		// first search, a few bits, reserved op mid-search, then 1/1
		send_item(OP_FIRST, 1'b1, 1'b1, 64'd0, a);
		send_item(OP_PAIR, 1'b1, 1'b0, 64'd0, a);
		send_item(OP_PAIR, 1'b0, 1'b1, 64'd0, a);
		send_item(OP_PAIR, 1'b0, 1'b0, 64'd0, a);
		send_item(OP_RESERVED, 1'b1, 1'b1, ALL_ONES, a);
		send_item(OP_PAIR, 1'b1, 1'b1, 64'd0, a);
		// pairs contradicting the previous ID
		send_item(OP_NEXT, 1'b0, 1'b0, ALL_ONES, a);
		send_item(OP_PAIR, 1'b0, 1'b1, 64'd0, a);
		send_item(OP_NEXT, 1'b1, 1'b1, 64'd0, a);
		send_item(OP_PAIR, 1'b1, 1'b0, ALL_ONES, a);
		// start ops abort a search in progress
		send_item(OP_NEXT, 1'b0, 1'b0, ALL_ONES, a);
		send_item(OP_PAIR, 1'b1, 1'b0, 64'd0, a);
		send_item(OP_FIRST, 1'b0, 1'b0, 64'd0, a);
		send_item(OP_PAIR, 1'b0, 1'b0, ALL_ONES, a);
		send_item(OP_NEXT, 1'b0, 1'b0, 64'd0, a);
		send_item(OP_NEXT, 1'b1, 1'b1, ALL_ONES, a);
		send_item(OP_PAIR, 1'b0, 1'b0, 64'd0, a);

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(99) < 80)
				enumerate_bus();
			else
				noise_burst();
		end
		steady = 1'b0;
		s_axis_tvalid <= 1'b0;

		guard = 0;
		while (chk.answers_due.size() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (chk.answers_due.size() != 0) begin
			$error("results never delivered: %0d", chk.answers_due.size());
			chk.failures++;
		end
		if (chk.failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

endmodule
